// ===== sv/rvdiv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvdiv_pkg
// Shared types and constants for the pipelined RV32 divide/remainder unit:
// request and response payloads, sign mode codes and pipeline geometry.
// ----------------------------------------------------------------------------
package rvdiv_pkg;

  localparam int unsigned HalfW    = 16;
  localparam int unsigned WordW    = 2 * HalfW;
  // One quotient bit is resolved per step stage
  localparam int unsigned NumSteps = WordW;
  // Operand stage, step stages, result stage
  localparam int unsigned Latency  = NumSteps + 2;

  typedef enum logic [1:0] {
    ModeUnsigned  = 2'd0,
    ModeSigned    = 2'd1,
    ModeFloor     = 2'd2,
    ModeSignedNum = 2'd3
  } rvdiv_mode_e;

  typedef struct packed {
    logic [HalfW-1:0] numerator_low;
    logic [HalfW-1:0] numerator_high;
    logic [HalfW-1:0] divisor_low;
    logic [HalfW-1:0] divisor_high;
    logic [1:0]       sign_mode;
  } rvdiv_req_t;

  typedef struct packed {
    logic [HalfW-1:0] quotient_low;
    logic [HalfW-1:0] quotient_high;
    logic [HalfW-1:0] remainder_low;
    logic [HalfW-1:0] remainder_high;
  } rvdiv_rsp_t;

  // Work carried down the step pipeline
  typedef struct packed {
    logic [WordW-1:0] rem;      // partial remainder
    logic [WordW-1:0] nq;       // numerator bits left, quotient bits shifted in
    logic [WordW-1:0] den;      // divisor magnitude
    logic             num_neg;  // remainder gets negated
    logic             q_flip;   // quotient gets negated
    logic             fix;      // ones' complement instead of two's complement
  } rvdiv_stage_t;

endpackage : rvdiv_pkg
`default_nettype wire

// ===== sv/rv32_divide_remainder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv32_divide_remainder_unit
// Fully pipelined 32-bit divide/remainder with RV32M sign handling, plus a
// floor mode (ones' complement) and a signed-numerator-only mode.
//
//   channel   ports                    transfer when
//   --------  -----------------------  ---------------------
//   request   start_i, busy_o, req_i   start_i && !busy_o
//   result    done_o, rsp_o            done_o (one cycle)
//
// One request can be taken in every cycle; busy_o stays low.
// Each result passes through one operand stage (magnitudes), 32
// restoring-division stages (one quotient bit each, one 33-bit subtract and
// select) and one result stage (sign restore).
// Reset clears only the valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module rv32_divide_remainder_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire rvdiv_pkg::rvdiv_req_t req_i,
  output logic                      done_o,
  output rvdiv_pkg::rvdiv_rsp_t     rsp_o
);
  import rvdiv_pkg::*;

  logic [WordW-1:0] num;
  logic [WordW-1:0] den;
  logic             num_neg;
  logic             den_neg;
  logic             fix;
  logic             accept;

  logic [NumSteps:0] vld_q;
  logic [NumSteps:0] vld_d;
  rvdiv_stage_t      stg_q [NumSteps+1];
  rvdiv_stage_t      stg_d [NumSteps+1];

  logic [WordW-1:0] quo_fin;
  logic [WordW-1:0] rem_fin;
  rvdiv_rsp_t       rsp_d;
  rvdiv_rsp_t       rsp_q;
  logic             done_q;

  // Never hold off a request
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Take operand magnitudes and sign decisions
  always_comb begin
    num     = {req_i.numerator_high, req_i.numerator_low};
    den     = {req_i.divisor_high, req_i.divisor_low};
    fix     = (req_i.sign_mode == ModeFloor);
    num_neg = (req_i.sign_mode != ModeUnsigned) && num[WordW-1];
    den_neg = (req_i.sign_mode == ModeSigned) && den[WordW-1];

    stg_d[0].rem     = '0;
    stg_d[0].nq      = num_neg ? (fix ? ~num : (~num + WordW'(1))) : num;
    stg_d[0].den     = den_neg ? (~den + WordW'(1)) : den;
    stg_d[0].num_neg = num_neg;
    // A zero divisor leaves the all-ones quotient unsigned
    stg_d[0].q_flip  = (num_neg ^ den_neg) && (den != '0);
    stg_d[0].fix     = fix;
  end

  // Resolve one quotient bit per stage
  for (genvar i = 0; i < NumSteps; i++) begin : g_step
    logic [WordW:0]   shifted;
    logic [WordW+1:0] diff;

    always_comb begin
      shifted      = {stg_q[i].rem, stg_q[i].nq[WordW-1]};
      diff         = {1'b0, shifted} - {2'b00, stg_q[i].den};
      stg_d[i+1]    = stg_q[i];
      stg_d[i+1].rem = diff[WordW+1] ? shifted[WordW-1:0] : diff[WordW-1:0];
      stg_d[i+1].nq  = {stg_q[i].nq[WordW-2:0], ~diff[WordW+1]};
    end
  end

  // Advance valid bits along with the work
  assign vld_d = {vld_q[NumSteps-1:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q[NumSteps];
    end
  end

  // Load each stage only when work enters it
  always_ff @(posedge clk_i) begin
    for (int unsigned s = 0; s <= NumSteps; s++) begin
      if (vld_d[s]) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  // Restore signs of quotient and remainder
  always_comb begin
    quo_fin = stg_q[NumSteps].nq;
    rem_fin = stg_q[NumSteps].rem;
    if (stg_q[NumSteps].q_flip) begin
      quo_fin = stg_q[NumSteps].fix ? ~quo_fin : (~quo_fin + WordW'(1));
    end
    if (stg_q[NumSteps].num_neg) begin
      rem_fin = stg_q[NumSteps].fix ? ~rem_fin : (~rem_fin + WordW'(1));
    end
    rsp_d.quotient_low   = quo_fin[HalfW-1:0];
    rsp_d.quotient_high  = quo_fin[WordW-1:HalfW];
    rsp_d.remainder_low  = rem_fin[HalfW-1:0];
    rsp_d.remainder_high = rem_fin[WordW-1:HalfW];
  end

  // Hold the result for its single output cycle
  always_ff @(posedge clk_i) begin
    if (vld_q[NumSteps]) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule : rv32_divide_remainder_unit
`default_nettype wire

// ===== sv/rvdiv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvdiv_checker
// Port-level checks for the divide/remainder unit: fixed latency between
// request and result, and divide-by-zero and unsigned remainder results.
// ----------------------------------------------------------------------------
module rvdiv_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start_i,
  input wire logic                  busy_o,
  input wire rvdiv_pkg::rvdiv_req_t req_i,
  input wire logic                  done_o,
  input wire rvdiv_pkg::rvdiv_rsp_t rsp_o
);
  import rvdiv_pkg::*;

  logic             req_xfer;
  logic [WordW-1:0] den_in;
  logic [WordW-1:0] quo_out;
  logic [WordW-1:0] rem_out;

  assign req_xfer = start_i && !busy_o;
  assign den_in   = {req_i.divisor_high, req_i.divisor_low};
  assign quo_out  = {rsp_o.quotient_high, rsp_o.quotient_low};
  assign rem_out  = {rsp_o.remainder_high, rsp_o.remainder_low};

  // Every request transfer yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |-> ##Latency done_o)
    else $error("result missing after request");

  // No result without a request transfer at the matching cycle
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_xfer, Latency))
    else $error("result without request");

  // Zero divisor gives an all-ones quotient in every mode
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(den_in, Latency) == '0)) |-> (quo_out == '1))
    else $error("zero divisor quotient not all ones");

  // Unsigned remainder stays below a nonzero divisor
  a_urem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(req_i.sign_mode, Latency) == ModeUnsigned)
            && ($past(den_in, Latency) != '0))
      |-> (rem_out < $past(den_in, Latency)))
    else $error("unsigned remainder not below divisor");

endmodule : rvdiv_checker

bind rv32_divide_remainder_unit rvdiv_checker u_rvdiv_checker (.*);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rv32_divide_remainder_unit. A queue of division
// jobs (directed corner cases, then random operands in all four sign modes)
// feeds a clocked driver with random gaps. A clocked monitor predicts each
// transferred request and checks every result, half by half, in order.
// ----------------------------------------------------------------------------
module testbench;

  import rvdiv_pkg::*;

  localparam int unsigned RandomJobs = 1600;
  localparam int unsigned IdleLimit  = 1000;

  typedef struct {
    rvdiv_req_t  req;
    int unsigned gap;    // idle cycles after this job is transferred
    bit          drain;  // hold this job until every result is back
  } div_job_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       start  = 1'b0;
  logic       busy;
  rvdiv_req_t req    = '0;
  logic       done;
  rvdiv_rsp_t rsp;

  div_job_t    div_jobs[$];
  rvdiv_rsp_t  pending_results[$];
  int unsigned total_jobs   = 0;
  int unsigned n_issued     = 0;
  int unsigned n_retired    = 0;
  int unsigned mismatches   = 0;
  int unsigned zero_divides = 0;
  int unsigned mode_hits [4] = '{0, 0, 0, 0};

  rv32_divide_remainder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Quotient and remainder as the unit should produce them
  function automatic rvdiv_rsp_t predict_quotient_remainder(rvdiv_req_t r);
    rvdiv_mode_e mode;
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] quo;
    logic [31:0] rem;
    logic [31:0] fix;
    logic        num_neg;
    logic        den_neg;
    logic        negate_quo;
    rvdiv_rsp_t  res;
    mode    = rvdiv_mode_e'(r.sign_mode);
    num     = {r.numerator_high, r.numerator_low};
    den     = {r.divisor_high, r.divisor_low};
    fix     = (mode == ModeFloor) ? 32'd1 : 32'd0;
    num_neg = (mode != ModeUnsigned) && num[31];
    den_neg = (mode == ModeSigned) && den[31];
    // Take magnitudes; floor mode uses ones' complement
    if (num_neg) num = (32'd0 - num) - fix;
    if (den_neg) den = (32'd0 - den) - fix;
    if (den == 32'd0) begin
      quo = '1;
      rem = num;
    end else begin
      quo = num / den;
      rem = num % den;
    end
    // A zero divisor keeps the all-ones quotient even for a negative numerator
    negate_quo = (num_neg != den_neg) ^ ((den == 32'd0) && num_neg);
    if (negate_quo) quo = (32'd0 - quo) - fix;
    if (num_neg) rem = (32'd0 - rem) - fix;
    res.quotient_low   = quo[15:0];
    res.quotient_high  = quo[31:16];
    res.remainder_low  = rem[15:0];
    res.remainder_high = rem[31:16];
    return res;
  endfunction

  function automatic void add_job(logic [31:0] num, logic [31:0] den, rvdiv_mode_e mode,
                                  int unsigned gap, bit drain);
    div_job_t job;
    job.req.numerator_low  = num[15:0];
    job.req.numerator_high = num[31:16];
    job.req.divisor_low    = den[15:0];
    job.req.divisor_high   = den[31:16];
    job.req.sign_mode      = mode;
    job.gap   = gap;
    job.drain = drain;
    div_jobs.push_back(job);
    total_jobs++;
  endfunction

  // Operand mix that favors sign boundaries, small values, powers of two and half patterns
  function automatic logic [31:0] draw_operand();
    logic [31:0] v;
    case ($urandom_range(0, 6))
      0:       v = $urandom_range(0, 15);
      1:       v = 32'd0 - 32'($urandom_range(1, 16));
      2:       v = 32'h8000_0000 + 32'($urandom_range(0, 3));
      3:       v = 32'h7fff_ffff - 32'($urandom_range(0, 3));
      4:       v = {($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000, 16'($urandom)};
      5:       v = 32'd1 << $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic check_half(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Driver: present the next job once the current one is transferred
  always @(posedge clk_i) begin
    int unsigned gap_left;
    bit          took;
    if (rst_ni) begin
      took = start && !busy;
      if (!start || took) begin
        if (div_jobs.size() == 0) begin
          start <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start    <= 1'b0;
        end else if (div_jobs[0].drain && (n_issued + took != n_retired)) begin
          start <= 1'b0;
        end else begin
          start    <= 1'b1;
          req      <= div_jobs[0].req;
          gap_left = div_jobs[0].gap;
          void'(div_jobs.pop_front());
        end
      end
    end else begin
      gap_left = 0;
      start    <= 1'b0;
    end
  end

  // Monitor: retire results first, then record the request transferred here
  always @(posedge clk_i) begin
    rvdiv_rsp_t want;
    if (rst_ni) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result mismatch: expected none, actual %h", $time, rsp);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_half("quotient_low", want.quotient_low, rsp.quotient_low);
          check_half("quotient_high", want.quotient_high, rsp.quotient_high);
          check_half("remainder_low", want.remainder_low, rsp.remainder_low);
          check_half("remainder_high", want.remainder_high, rsp.remainder_high);
          n_retired <= n_retired + 1;
        end
      end
      if (start && !busy) begin
        pending_results.push_back(predict_quotient_remainder(req));
        n_issued <= n_issued + 1;
        mode_hits[req.sign_mode]++;
        if ({req.divisor_high, req.divisor_low} == 32'd0) zero_divides++;
      end
    end
  end

  // Job list, reset, end of run
  initial begin
    logic [31:0] edge_num [0:5];
    logic [31:0] edge_den [0:5];
    logic [31:0] den;
    int unsigned idle;
    bit          timed_out;
    bit          quiet;
    edge_num[0] = 32'h8000_0000; edge_den[0] = 32'hffff_ffff;  // signed overflow
    edge_num[1] = 32'hffff_fff9; edge_den[1] = 32'h0000_0000;  // negative over zero
    edge_num[2] = 32'h0000_1234; edge_den[2] = 32'h0000_0000;  // positive over zero
    edge_num[3] = 32'hffff_ffff; edge_den[3] = 32'h0000_0001;
    edge_num[4] = 32'hffff_fff9; edge_den[4] = 32'h0000_0002;  // remainder sign
    edge_num[5] = 32'h7fff_ffff; edge_den[5] = 32'h8000_0000;

    // Directed corners, back to back, in every mode
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 6; k++) begin
        add_job(edge_num[k], edge_den[k], rvdiv_mode_e'(m), 0, 1'b0);
      end
    end

    // Random jobs in stretches that are either gapless or gappy
    quiet = 1'b0;
    for (int n = 0; n < RandomJobs; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
      den = ($urandom_range(0, 15) == 0) ? 32'd0 : draw_operand();
      add_job(draw_operand(), den, rvdiv_mode_e'($urandom_range(0, 3)),
              quiet ? 0 : $urandom_range(0, 10),
              (n == 0) || ($urandom_range(0, 199) == 0));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Run until every job is transferred and retired, or nothing moves
    idle      = 0;
    timed_out = 1'b0;
    while (!timed_out && !(n_issued == total_jobs && n_retired == n_issued)) begin
      @(posedge clk_i);
      if ((start && !busy) || done) idle = 0;
      else idle++;
      if (idle >= IdleLimit) timed_out = 1'b1;
    end

    if (timed_out) begin
      $display("%0t ns: no transfer for %0d cycles", $time, IdleLimit);
      $display("Simulation FAILED");
    end else begin
      // Catch any stray result
      repeat (Latency + 16) @(posedge clk_i);
      $display("Checked %0d divisions: unsigned %0d, signed %0d, floor %0d, signed-numerator %0d",
               n_retired, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
      $display("Zero divisors %0d, mismatches %0d", zero_divides, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
    end
    $finish;
  end

endmodule
